>>> rtl/rmq_pkg.sv
`timescale 1ns / 1ps

package rmq_pkg;

    // Field format of the matrix and quaternion ports.
    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 30;

    // Internal widths.
    localparam int TW          = 35;               // trace, scale radicand source, direction
    localparam int UW          = 32;               // |v| >> 2
    localparam int RAD_W       = 64;               // square root radicand
    localparam int ROOT_W      = 32;               // square root result
    localparam int REM_W       = ROOT_W + 2;       // square root partial remainder
    localparam int SQRT_STAGES = ROOT_W;           // one root bit per stage
    localparam int SW          = ROOT_W + 1;       // s = 2 * root
    localparam int QW          = 31;               // quotient bits, result never exceeds 2^30
    localparam int DIV_STAGES  = QW;               // one quotient bit per stage
    localparam int LANES       = 4;

    // Configuration.
    localparam int EPS_W       = 16;
    localparam int PROD_W      = EPS_W + SW;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1074;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam logic REG_IDX_EPSILON = 1'b0;

    // Request queue between the front and back parts.
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = FIFO_AW + 1;

    localparam logic signed [DATA_WIDTH-1:0] ONE_OUT = 32'sh4000_0000;
    localparam logic signed [TW-1:0]         ONE_Q30 = 35'sh0_4000_0000;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] m00;
        logic signed [DATA_WIDTH-1:0] m01;
        logic signed [DATA_WIDTH-1:0] m02;
        logic signed [DATA_WIDTH-1:0] m10;
        logic signed [DATA_WIDTH-1:0] m11;
        logic signed [DATA_WIDTH-1:0] m12;
        logic signed [DATA_WIDTH-1:0] m20;
        logic signed [DATA_WIDTH-1:0] m21;
        logic signed [DATA_WIDTH-1:0] m22;
    } rmq_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quat_w;
        logic signed [DATA_WIDTH-1:0] quat_x;
        logic signed [DATA_WIDTH-1:0] quat_y;
        logic signed [DATA_WIDTH-1:0] quat_z;
    } rmq_out_t;

    typedef enum logic [3:0] {
        BR_W = 4'b0001,
        BR_X = 4'b0010,
        BR_Y = 4'b0100,
        BR_Z = 4'b1000
    } rmq_branch_t;

    // Classified request passed from the front part to the back part.
    typedef struct packed {
        logic [LANES-1:0]         neg;
        logic [LANES-1:0][UW-1:0] u;
        logic [RAD_W-1:0]         rad;
    } rmq_work_t;

    typedef struct packed {
        logic [LANES-1:0]         neg;
        logic [LANES-1:0][UW-1:0] u;
    } rmq_side_t;

    typedef struct packed {
        logic             deg_s;
        logic             deg_m;
        logic [LANES-1:0] neg;
    } rmq_flag_t;

    typedef struct packed {
        logic almost_full;
        logic empty;
    } rmq_fifo_stat_t;

endpackage

>>> rtl/rmq_front.sv
`timescale 1ns / 1ps

module rmq_front import rmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  rmq_in_t   matrix,
    output logic      push,
    output rmq_work_t item
);

    logic signed [TW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [TW-1:0] tr, t;
    logic signed [TW-1:0] v [LANES];
    logic [TW-1:0]        absv [LANES];
    rmq_branch_t          branch;
    rmq_work_t            item_next;
    logic                 push_reg;
    rmq_work_t            item_reg;

    always_comb
    begin
        a00 = TW'(matrix.m00);
        a01 = TW'(matrix.m01);
        a02 = TW'(matrix.m02);
        a10 = TW'(matrix.m10);
        a11 = TW'(matrix.m11);
        a12 = TW'(matrix.m12);
        a20 = TW'(matrix.m20);
        a21 = TW'(matrix.m21);
        a22 = TW'(matrix.m22);
        tr  = a00 + a11 + a22;

        if (tr > 0)
            branch = BR_W;
        else if (a00 > a11 && a00 > a22)
            branch = BR_X;
        else if (a11 > a22)
            branch = BR_Y;
        else
            branch = BR_Z;

        case (branch)
            BR_W:
            begin
                t    = tr + ONE_Q30;
                v[0] = t;
                v[1] = a21 - a12;
                v[2] = a02 - a20;
                v[3] = a10 - a01;
            end
            BR_X:
            begin
                t    = ONE_Q30 + a00 - a11 - a22;
                v[0] = a21 - a12;
                v[1] = t;
                v[2] = a01 + a10;
                v[3] = a02 + a20;
            end
            BR_Y:
            begin
                t    = ONE_Q30 + a11 - a00 - a22;
                v[0] = a02 - a20;
                v[1] = a01 + a10;
                v[2] = t;
                v[3] = a12 + a21;
            end
            default:
            begin
                t    = ONE_Q30 + a22 - a00 - a11;
                v[0] = a10 - a01;
                v[1] = a02 + a20;
                v[2] = a12 + a21;
                v[3] = t;
            end
        endcase

        // A radicand that is zero or negative gives a zero scale.
        item_next.rad = (t > 0) ? {t[RAD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}} : '0;
        for (int i = 0; i < LANES; i++)
        begin
            absv[i]          = v[i][TW-1] ? -v[i] : v[i];
            item_next.neg[i] = v[i][TW-1];
            item_next.u[i]   = absv[i][UW+1:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            push_reg <= 1'b0;
        else
            push_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign push = push_reg;
    assign item = item_reg;

endmodule

>>> rtl/rmq_fifo.sv
`timescale 1ns / 1ps

module rmq_fifo import rmq_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rmq_work_t      wdata,
    output logic           pop,
    output rmq_work_t      rdata,
    output rmq_fifo_stat_t stat
);

    rmq_work_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;

    // The back part never stalls, so the head leaves whenever there is one.
    assign pop   = (count_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // Leave room for the request still held in the front register.
    assign stat.almost_full = (count_reg >= FIFO_CW'(FIFO_DEPTH - 1));
    assign stat.empty       = !pop;

endmodule

>>> rtl/rmq_isqrt.sv
`timescale 1ns / 1ps

module rmq_isqrt import rmq_pkg::*;
(
    input  logic              clk,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]  x_reg  [SQRT_STAGES];
    logic [REM_W-1:0]  r_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] q_reg  [SQRT_STAGES];
    logic [RAD_W-1:0]  x_in   [SQRT_STAGES];
    logic [REM_W-1:0]  r_in   [SQRT_STAGES];
    logic [ROOT_W-1:0] q_in   [SQRT_STAGES];
    logic [RAD_W-1:0]  x_next [SQRT_STAGES];
    logic [REM_W-1:0]  r_next [SQRT_STAGES];
    logic [ROOT_W-1:0] q_next [SQRT_STAGES];

    // Each stage brings down two radicand bits and decides one root bit.
    always_comb
    begin
        logic [REM_W+1:0] r_sh;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        logic             ge;

        x_in[0] = rad;
        r_in[0] = '0;
        q_in[0] = '0;
        for (int k = 1; k < SQRT_STAGES; k++)
        begin
            x_in[k] = x_reg[k-1];
            r_in[k] = r_reg[k-1];
            q_in[k] = q_reg[k-1];
        end

        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            r_sh      = {r_in[k], x_in[k][RAD_W-1 -: 2]};
            trial     = {2'b00, q_in[k], 2'b01};
            ge        = (r_sh >= trial);
            diff      = r_sh - trial;
            r_next[k] = ge ? diff[REM_W-1:0] : r_sh[REM_W-1:0];
            q_next[k] = {q_in[k][ROOT_W-2:0], ge};
            x_next[k] = {x_in[k][RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            x_reg[k] <= x_next[k];
            r_reg[k] <= r_next[k];
            q_reg[k] <= q_next[k];
        end
    end

    assign root = q_reg[SQRT_STAGES-1];

endmodule

>>> rtl/rmq_div.sv
`timescale 1ns / 1ps

module rmq_div import rmq_pkg::*;
(
    input  logic                     clk,
    input  logic [LANES-1:0][UW-1:0] num,
    input  logic [UW-1:0]            den,
    output logic [LANES-1:0][QW-1:0] quo
);

    // Computes floor(num * 2^30 / den) for four lanes sharing one divisor.
    // num never exceeds den, so the quotient fits in QW bits.
    logic [UW-1:0] d_reg  [DIV_STAGES];
    logic [UW-1:0] r_reg  [LANES][DIV_STAGES];
    logic [QW-1:0] lo_reg [LANES][DIV_STAGES];
    logic [QW-1:0] q_reg  [LANES][DIV_STAGES];
    logic [UW-1:0] d_in   [DIV_STAGES];
    logic [UW-1:0] r_in   [LANES][DIV_STAGES];
    logic [QW-1:0] lo_in  [LANES][DIV_STAGES];
    logic [QW-1:0] q_in   [LANES][DIV_STAGES];
    logic [UW-1:0] r_next [LANES][DIV_STAGES];
    logic [QW-1:0] lo_next[LANES][DIV_STAGES];
    logic [QW-1:0] q_next [LANES][DIV_STAGES];

    always_comb
    begin
        logic [UW:0] r_sh;
        logic [UW:0] diff;
        logic        ge;

        d_in[0] = den;
        for (int k = 1; k < DIV_STAGES; k++)
            d_in[k] = d_reg[k-1];

        for (int l = 0; l < LANES; l++)
        begin
            r_in[l][0]  = {1'b0, num[l][UW-1:1]};
            lo_in[l][0] = {num[l][0], {(QW-1){1'b0}}};
            q_in[l][0]  = '0;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                r_in[l][k]  = r_reg[l][k-1];
                lo_in[l][k] = lo_reg[l][k-1];
                q_in[l][k]  = q_reg[l][k-1];
            end
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                r_sh          = {r_in[l][k], lo_in[l][k][QW-1]};
                ge            = (r_sh >= {1'b0, d_in[k]});
                diff          = r_sh - {1'b0, d_in[k]};
                r_next[l][k]  = ge ? diff[UW-1:0] : r_sh[UW-1:0];
                q_next[l][k]  = {q_in[l][k][QW-2:0], ge};
                lo_next[l][k] = {lo_in[l][k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            d_reg[k] <= d_in[k];
            for (int l = 0; l < LANES; l++)
            begin
                r_reg[l][k]  <= r_next[l][k];
                lo_reg[l][k] <= lo_next[l][k];
                q_reg[l][k]  <= q_next[l][k];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            quo[l] = q_reg[l][DIV_STAGES-1];
    end

endmodule

>>> rtl/rmq_back.sv
`timescale 1ns / 1ps

module rmq_back import rmq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rmq_work_t        item,
    input  logic [EPS_W-1:0] epsilon,
    output logic             done,
    output rmq_out_t         quat
);

    // Squares of the four components.
    logic                    v1_reg;
    logic [RAD_W-1:0]        sq1_reg [LANES];
    logic [RAD_W-1:0]        rad1_reg;
    rmq_side_t               side1_reg;

    // Sum of squares.
    logic                    v2_reg;
    logic [RAD_W-1:0]        sum2_reg;
    logic [RAD_W-1:0]        rad2_reg;
    rmq_side_t               side2_reg;

    // Side line matching the square root latency.
    logic                    sv_reg [SQRT_STAGES];
    rmq_side_t               sd_reg [SQRT_STAGES];
    logic [ROOT_W-1:0]       root_s, root_m;
    logic [SW-1:0]           s_next;

    // Scale, magnitude and threshold product.
    logic                    v3_reg;
    logic [SW-1:0]           s3_reg;
    logic [ROOT_W-1:0]       mag3_reg;
    logic [PROD_W-1:0]       prod3_reg;
    rmq_side_t               side3_reg;
    rmq_flag_t               flag3;

    // Flag line matching the divider latency.
    logic                    fv_reg [DIV_STAGES];
    rmq_flag_t               fl_reg [DIV_STAGES];
    logic [LANES-1:0][QW-1:0] quo;

    logic                    done_reg;
    rmq_out_t                quat_reg, quat_next;
    logic [DATA_WIDTH-1:0]   lane [LANES];

    rmq_isqrt u_sqrt_scale
    (
        .clk  (clk),
        .rad  (rad2_reg),
        .root (root_s)
    );

    rmq_isqrt u_sqrt_mag
    (
        .clk  (clk),
        .rad  (sum2_reg),
        .root (root_m)
    );

    rmq_div u_div
    (
        .clk (clk),
        .num (side3_reg.u),
        .den (mag3_reg),
        .quo (quo)
    );

    assign s_next = {root_s, 1'b0};

    always_comb
    begin
        flag3.deg_s = (s3_reg <= SW'(epsilon));
        flag3.deg_m = ({mag3_reg, 32'd0} <= RAD_W'(prod3_reg));
        flag3.neg   = side3_reg.neg;
    end

    always_comb
    begin
        rmq_flag_t f;
        logic [DATA_WIDTH-1:0] mq;

        f = fl_reg[DIV_STAGES-1];
        for (int i = 0; i < LANES; i++)
        begin
            mq      = {1'b0, quo[i]};
            lane[i] = f.neg[i] ? -mq : mq;
        end
        if (f.deg_s)
        begin
            quat_next.quat_w = ONE_OUT;
            quat_next.quat_x = '0;
            quat_next.quat_y = '0;
            quat_next.quat_z = '0;
        end
        else if (f.deg_m)
        begin
            quat_next = '0;
        end
        else
        begin
            quat_next.quat_w = lane[0];
            quat_next.quat_x = lane[1];
            quat_next.quat_y = lane[2];
            quat_next.quat_z = lane[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 0; k < SQRT_STAGES; k++)
                sv_reg[k] <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
                fv_reg[k] <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            sv_reg[0] <= v2_reg;
            for (int k = 1; k < SQRT_STAGES; k++)
                sv_reg[k] <= sv_reg[k-1];
            v3_reg    <= sv_reg[SQRT_STAGES-1];
            fv_reg[0] <= v3_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                fv_reg[k] <= fv_reg[k-1];
            done_reg  <= fv_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
            sq1_reg[i] <= RAD_W'(item.u[i]) * RAD_W'(item.u[i]);
        rad1_reg      <= item.rad;
        side1_reg.u   <= item.u;
        side1_reg.neg <= item.neg;

        // Cannot overflow: the largest component is below 2^31 and the rest below 2^30.
        sum2_reg  <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2] + sq1_reg[3];
        rad2_reg  <= rad1_reg;
        side2_reg <= side1_reg;

        sd_reg[0] <= side2_reg;
        for (int k = 1; k < SQRT_STAGES; k++)
            sd_reg[k] <= sd_reg[k-1];

        s3_reg    <= s_next;
        mag3_reg  <= root_m;
        prod3_reg <= PROD_W'(epsilon) * PROD_W'(s_next);
        side3_reg <= sd_reg[SQRT_STAGES-1];

        fl_reg[0] <= flag3;
        for (int k = 1; k < DIV_STAGES; k++)
            fl_reg[k] <= fl_reg[k-1];

        quat_reg <= quat_next;
    end

    assign done = done_reg;
    assign quat = quat_reg;

endmodule

>>> rtl/rotation_matrix_to_unit_quaternion.sv
`timescale 1ns / 1ps

// Rotation matrix to unit quaternion (Shepperd's method) in Q2.30 fixed point.
// A request is a 3x3 matrix on the matrix port. It is taken at a rising edge
// where start is high and busy is low. One result per request appears on the
// quat port for exactly one cycle, marked by done, in request order.
// The receiver cannot hold results off, and the pipeline never needs it to.
// The pipeline holds the two 32-stage square roots, which run side by side,
// and the 31-stage divider, which has four lanes. One request can be
// accepted every cycle. busy only rises if the request queue between the
// classifying front part and the arithmetic back part fills, which it does
// not while the back part drains it every cycle. The epsilon register sits
// at byte address 0 on the APB port. The user must write it only while no
// request is in flight; the block itself does not enforce this. Reset
// clears every valid bit, empties the queue and sets epsilon to 1074; there
// is no clearing pass, so the block can take a request in the first cycle
// after reset.

module rotation_matrix_to_unit_quaternion import rmq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rmq_in_t           matrix,
    output logic              done,
    output rmq_out_t          quat,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [EPS_W-1:0] eps_reg;
    logic             cfg_write;
    logic             accept;
    logic             push;
    logic             pop;
    rmq_work_t        front_item;
    rmq_work_t        back_item;
    rmq_fifo_stat_t   fifo_stat;

    // The APB port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg_write && (paddr[APB_AW-1] == REG_IDX_EPSILON))
            eps_reg <= pwdata[EPS_W-1:0];
    end

    assign prdata = (paddr[APB_AW-1] == REG_IDX_EPSILON) ? APB_DW'(eps_reg) : '0;

    assign busy   = fifo_stat.almost_full;
    assign accept = start && !busy;

    // Front part: works out the branch, the direction vector and the scale radicand.
    rmq_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .matrix (matrix),
        .push   (push),
        .item   (front_item)
    );

    rmq_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .pop   (pop),
        .rdata (back_item),
        .stat  (fifo_stat)
    );

    // Back part: square roots, degeneracy tests and normalising division.
    rmq_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pop),
        .item     (back_item),
        .epsilon  (eps_reg),
        .done     (done),
        .quat     (quat)
    );

endmodule

>>> bench/rotation_matrix_to_unit_quaternion_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the matrix to quaternion converter. Requests are
// driven on the falling edge, results sampled on the rising edge, and every
// result is compared field by field with a prediction made when the request
// was accepted.
module rotation_matrix_to_unit_quaternion_test;
    import rmq_pkg::*;

    localparam int LATENCY     = 68;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    rmq_in_t           matrix;
    logic              done;
    rmq_out_t          quat;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Predicted quaternions, oldest first, and the predictor's own epsilon.
    rmq_out_t          quat_expected[$];
    logic [EPS_W-1:0]  eps_model;
    int                error_count;
    int                cycle_count;
    bit                quiet_stretch;

    rotation_matrix_to_unit_quaternion u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .matrix  (matrix),
        .done    (done),
        .quat    (quat),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root by the bitwise method, rounding down.
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Signed Q30 magnitude with its sign, clamped to the output range.
    function automatic logic signed [31:0] pack_lane(input bit neg, input logic [63:0] m);
        longint x;
        if (m > 64'h8000_0000)
            m = 64'h8000_0000;
        x = neg ? -longint'(m) : longint'(m);
        if (x > 64'sh7fff_ffff)
            x = 64'sh7fff_ffff;
        return x[31:0];
    endfunction

    // Shepperd's method at the block's widths: pick the branch from the trace
    // or the largest diagonal, test the scale and magnitude, normalise, saturate.
    function automatic rmq_out_t predict_quaternion(input rmq_in_t mi);
        longint      a[9];
        longint      v[4];
        longint      t;
        longint      tr;
        logic [63:0] s;
        logic [63:0] u[4];
        logic [63:0] sum;
        logic [63:0] mag;
        rmq_out_t    q;
        a[0] = mi.m00; a[1] = mi.m01; a[2] = mi.m02;
        a[3] = mi.m10; a[4] = mi.m11; a[5] = mi.m12;
        a[6] = mi.m20; a[7] = mi.m21; a[8] = mi.m22;
        tr = a[0] + a[4] + a[8];
        if (tr > 0)
        begin
            t = tr + (64'sd1 << 30);
            v[0] = t; v[1] = a[7] - a[5]; v[2] = a[2] - a[6]; v[3] = a[3] - a[1];
        end
        else if (a[0] > a[4] && a[0] > a[8])
        begin
            t = (64'sd1 << 30) + a[0] - a[4] - a[8];
            v[0] = a[7] - a[5]; v[1] = t; v[2] = a[1] + a[3]; v[3] = a[2] + a[6];
        end
        else if (a[4] > a[8])
        begin
            t = (64'sd1 << 30) + a[4] - a[0] - a[8];
            v[0] = a[2] - a[6]; v[1] = a[1] + a[3]; v[2] = t; v[3] = a[5] + a[7];
        end
        else
        begin
            t = (64'sd1 << 30) + a[8] - a[0] - a[4];
            v[0] = a[3] - a[1]; v[1] = a[2] + a[6]; v[2] = a[5] + a[7]; v[3] = t;
        end
        s = (t > 0) ? 2 * root_floor(64'(t) << 30) : 64'd0;
        if (s <= 64'(eps_model))
        begin
            q = '0;
            q.quat_w = ONE_OUT;
            return q;
        end
        sum = 64'd0;
        for (int i = 0; i < 4; i++)
        begin
            u[i] = (v[i] < 0 ? 64'(-v[i]) : 64'(v[i])) >> 2;
            sum = sum + u[i] * u[i];
        end
        mag = root_floor(sum);
        if (mag == 64'd0 || (mag << 32) <= 64'(eps_model) * s)
            return '0;
        q.quat_w = pack_lane(v[0] < 0, (u[0] << 30) / mag);
        q.quat_x = pack_lane(v[1] < 0, (u[1] << 30) / mag);
        q.quat_y = pack_lane(v[2] < 0, (u[2] << 30) / mag);
        q.quat_z = pack_lane(v[3] < 0, (u[3] << 30) / mag);
        return q;
    endfunction

    // Result checker: every done cycle must match the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (quat_expected.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, quat);
                error_count++;
            end
            else
            begin
                rmq_out_t e;
                e = quat_expected.pop_front();
                if (quat.quat_w !== e.quat_w)
                begin
                    $display("%0t: quat_w expected %h actual %h", $time, e.quat_w, quat.quat_w);
                    error_count++;
                end
                if (quat.quat_x !== e.quat_x)
                begin
                    $display("%0t: quat_x expected %h actual %h", $time, e.quat_x, quat.quat_x);
                    error_count++;
                end
                if (quat.quat_y !== e.quat_y)
                begin
                    $display("%0t: quat_y expected %h actual %h", $time, e.quat_y, quat.quat_y);
                    error_count++;
                end
                if (quat.quat_z !== e.quat_z)
                begin
                    $display("%0t: quat_z expected %h actual %h", $time, e.quat_z, quat.quat_z);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sends one request. start is held across consecutive requests and only
    // dropped for random idle cycles, so it is never lowered and raised in
    // the same step. The prediction is made when the request is taken.
    task automatic send_request(input rmq_in_t mi);
        if (!quiet_stretch)
        begin
            while ($urandom_range(99) < 12)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start  <= 1'b1;
        matrix <= mi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        quat_expected.push_back(predict_quaternion(mi));
        @(negedge clk);
    endtask

    // Drops start, waits for every prediction to be matched, then lets the pipeline run on idle.
    task automatic drain;
        start <= 1'b0;
        while (quat_expected.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // APB write with setup and access phases; read back for a sanity check.
    task automatic write_epsilon(input logic [EPS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        if (prdata !== APB_DW'(value))
        begin
            $display("%0t: epsilon read back expected %h actual %h", $time, value, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        eps_model = value;
    endtask

    function automatic rmq_in_t diag_matrix(input int d0, input int d1, input int d2);
        rmq_in_t mi;
        mi = '0;
        mi.m00 = d0; mi.m11 = d1; mi.m22 = d2;
        return mi;
    endfunction

    function automatic rmq_in_t random_raw;
        rmq_in_t mi;
        mi.m00 = $urandom; mi.m01 = $urandom; mi.m02 = $urandom;
        mi.m10 = $urandom; mi.m11 = $urandom; mi.m12 = $urandom;
        mi.m20 = $urandom; mi.m21 = $urandom; mi.m22 = $urandom;
        return mi;
    endfunction

    // A plausible rotation: entries within +-1.0, with one diagonal entry
    // sometimes replaced by a non-negative value up to 1.0 that favours its branch.
    function automatic rmq_in_t random_rotation;
        rmq_in_t mi;
        int      big;
        int      jit;
        mi.m00 = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        mi.m01 = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        mi.m02 = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        mi.m10 = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        mi.m11 = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        mi.m12 = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        mi.m20 = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        mi.m21 = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        mi.m22 = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        big = $urandom_range(0, 32'h4000_0000);
        jit = $urandom_range(0, 3);
        case (jit)
            0: mi.m00 = big;
            1: mi.m11 = big;
            2: mi.m22 = big;
            default: ;
        endcase
        return mi;
    endfunction

    // Directed cases: identity, each branch, all extremes, traces around
    // zero and the zero matrix.
    task automatic test_directed;
        rmq_in_t mi;
        send_request(diag_matrix(32'h4000_0000, 32'h4000_0000, 32'h4000_0000));
        send_request(diag_matrix(32'h4000_0000, -32'sh4000_0000, -32'sh4000_0000));
        send_request(diag_matrix(-32'sh4000_0000, 32'h4000_0000, -32'sh4000_0000));
        send_request(diag_matrix(-32'sh4000_0000, -32'sh4000_0000, 32'h4000_0000));
        send_request(diag_matrix(0, 0, 0));
        // Traces of 1.0, well below zero and just above zero.
        send_request(diag_matrix(0, 32'h2000_0000, 32'h2000_0000));
        send_request(diag_matrix(-32'sh2000_0000, -32'sh2000_0000, -32'sh2000_0000));
        send_request(diag_matrix(-32'sh1fff_ffff, 32'h1000_0000, 32'h1000_0000));
        // Diagonal entries whose sum runs past the input range.
        send_request(diag_matrix(-32'sh4000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
        mi = '0;
        send_request(mi);
        mi = '1;
        send_request(mi);
        mi = {9{32'h7fff_ffff}};
        send_request(mi);
        mi = {9{32'h8000_0000}};
        send_request(mi);
        mi = {9{32'h5555_5555}};
        send_request(mi);
        mi = {9{32'haaaa_aaaa}};
        send_request(mi);
        mi = diag_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        mi.m21 = 32'h7fff_ffff; mi.m12 = 32'h8000_0000;
        send_request(mi);
        // Rotation of 90 degrees about z.
        mi = '0;
        mi.m01 = -32'sh4000_0000; mi.m10 = 32'h4000_0000; mi.m22 = 32'h4000_0000;
        send_request(mi);
        drain();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 75)
                send_request(random_rotation());
            else
                send_request(random_raw());
        end
        drain();
    endtask

    // Stretch with start held high throughout.
    task automatic test_back_to_back(input int count);
        quiet_stretch = 1'b1;
        test_random(count);
        quiet_stretch = 1'b0;
    endtask

    // Runs the tests at the largest, zero and a random threshold, then restores 1074.
    task automatic test_epsilon_settings;
        write_epsilon(16'hffff);
        test_directed();
        test_random(120);
        write_epsilon(16'd0);
        test_directed();
        test_random(120);
        write_epsilon(16'($urandom));
        test_random(100);
        write_epsilon(16'd1074);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        matrix        = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        eps_model     = EPS_RESET;
        error_count   = 0;
        cycle_count   = 0;
        quiet_stretch = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(300);
        test_back_to_back(200);
        test_epsilon_settings();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_fifo.sv
rtl/rmq_isqrt.sv
rtl/rmq_div.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_unit_quaternion.sv
bench/rotation_matrix_to_unit_quaternion_test.sv
